/* src/ccext_pkg.sv */
// shared types and constants for the cycle count extend and split unit
package ccext_pkg;

   localparam int COUNTER_WIDTH_DEF = 32;
   localparam int SAMPLE_W          = 32;
   localparam int WRAP_W            = 32;
   localparam int EXT_W             = 64;
   localparam int MHZ_W             = 10;
   localparam int SEC_W             = 32;
   localparam int SUB_W             = 10;
   localparam int TOTAL_W           = 52;
   localparam int REM_W             = 30;
   localparam int FIFO_DEPTH        = 2;

   localparam logic [MHZ_W-1:0] MHZ_RESET = MHZ_W'(1);
   localparam logic [19:0]      US_PER_S  = 20'd1000000;
   localparam logic [9:0]       US_PER_MS = 10'd1000;
   localparam logic [SUB_W-1:0] SUB_LIMIT = SUB_W'(1000);

   typedef struct packed {
      logic [EXT_W-1:0] ext;
      logic [MHZ_W-1:0] mhz;
   } item_type;

endpackage

/* src/ccext_front.sv */
// front end: sample masking, wrap detection, extended count and clock capture
module ccext_front #(
   parameter int COUNTER_WIDTH = ccext_pkg::COUNTER_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [ccext_pkg::SAMPLE_W-1:0] req_counter_sample,
   input  logic                          csr_wr_en,
   input  logic [ccext_pkg::MHZ_W-1:0]   csr_wr_data,
   input  logic                          q_full,
   output logic                          q_push,
   output ccext_pkg::item_type           q_item
);

   logic [COUNTER_WIDTH-1:0]         prev_ff, prev_in;
   logic [ccext_pkg::WRAP_W-1:0]     wrap_ff, wrap_in;
   logic [ccext_pkg::MHZ_W-1:0]      mhz_ff, mhz_in;
   logic [COUNTER_WIDTH-1:0]         sample;
   logic [ccext_pkg::WRAP_W-1:0]     wrap_next;

   assign sample    = req_counter_sample[COUNTER_WIDTH-1:0];
   assign q_push    = push & ~q_full;
   assign wrap_next = wrap_ff + ccext_pkg::WRAP_W'(sample < prev_ff);

   always_comb begin
      prev_in = q_push ? sample : prev_ff;
      wrap_in = q_push ? wrap_next : wrap_ff;
      mhz_in  = csr_wr_en ? csr_wr_data : mhz_ff;
   end

   // zero clock is taken as 1 MHz so no divisor is zero
   always_comb begin
      q_item.ext = (ccext_pkg::EXT_W'(wrap_next) << COUNTER_WIDTH)
                   | ccext_pkg::EXT_W'(sample);
      q_item.mhz = (mhz_ff == '0) ? ccext_pkg::MHZ_W'(1) : mhz_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         wrap_ff <= '0;
         mhz_ff  <= ccext_pkg::MHZ_RESET;
      end else begin
         prev_ff <= prev_in;
         wrap_ff <= wrap_in;
         mhz_ff  <= mhz_in;
      end
   end

endmodule

/* src/ccext_fifo.sv */
// short flop queue between front and back
module ccext_fifo #(
   parameter int DEPTH = ccext_pkg::FIFO_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr,
   input  ccext_pkg::item_type wr_item,
   input  logic                rd,
   output ccext_pkg::item_type rd_item,
   output logic                full,
   output logic                empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ccext_pkg::item_type   mem_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr & ~full;
   assign do_rd   = rd & ~empty;
   assign rd_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(do_wr) - CNT_W'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule

/* src/ccext_back.sv */
// back end: shared restoring divider for the time split, total and result register
module ccext_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_empty,
   input  ccext_pkg::item_type            q_item,
   output logic                           q_pop,
   input  logic                           pop,
   output logic                           empty,
   output logic [ccext_pkg::EXT_W-1:0]    rsp_extended_count,
   output logic [ccext_pkg::SEC_W-1:0]    rsp_seconds,
   output logic [ccext_pkg::SUB_W-1:0]    rsp_milliseconds,
   output logic [ccext_pkg::SUB_W-1:0]    rsp_microseconds,
   output logic [ccext_pkg::TOTAL_W-1:0]  rsp_total_microseconds
);

   localparam int EXT_W  = ccext_pkg::EXT_W;
   localparam int REM_W  = ccext_pkg::REM_W;
   localparam int SUB_W  = ccext_pkg::SUB_W;
   localparam int ITER_W = $clog2(EXT_W);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SEC   = 3'd1;
   localparam logic [2:0] ST_MS    = 3'd2;
   localparam logic [2:0] ST_US    = 3'd3;
   localparam logic [2:0] ST_TOTAL = 3'd4;

   logic [2:0]                     state_ff, state_in;
   logic [ITER_W-1:0]              iter_ff, iter_in;
   logic [REM_W-1:0]               rem_ff, rem_in;
   logic [EXT_W-1:0]               quo_ff, quo_in;
   logic [EXT_W-1:0]               ext_ff, ext_in;
   logic [ccext_pkg::MHZ_W-1:0]    mhz_ff, mhz_in;
   logic [ccext_pkg::SEC_W-1:0]    sec_ff, sec_in;
   logic [SUB_W-1:0]               ms_ff, ms_in;
   logic [SUB_W-1:0]               us_ff, us_in;
   logic                           valid_ff, valid_in;
   logic [EXT_W-1:0]               o_ext_ff, o_ext_in;
   logic [ccext_pkg::SEC_W-1:0]    o_sec_ff, o_sec_in;
   logic [SUB_W-1:0]               o_ms_ff, o_ms_in;
   logic [SUB_W-1:0]               o_us_ff, o_us_in;
   logic [ccext_pkg::TOTAL_W-1:0]  o_tot_ff, o_tot_in;

   logic [REM_W-1:0]  hz, khz, divisor;
   logic [REM_W:0]    shifted;
   logic [REM_W+1:0]  diff;
   logic              ge;
   logic [REM_W-1:0]  step_rem;
   logic [EXT_W-1:0]  step_quo;
   logic              out_free;

   // divisors from the clock in MHz, constant multiplies
   assign hz  = REM_W'(mhz_ff) * REM_W'(ccext_pkg::US_PER_S);
   assign khz = REM_W'(mhz_ff) * REM_W'(ccext_pkg::US_PER_MS);

   always_comb begin
      unique case (state_ff)
         ST_SEC:  divisor = hz;
         ST_MS:   divisor = khz;
         default: divisor = REM_W'(mhz_ff);
      endcase
   end

   // one restoring step: bring in the next dividend bit, subtract if it fits
   assign shifted  = {rem_ff, quo_ff[EXT_W-1]};
   assign diff     = {1'b0, shifted} - {2'b00, divisor};
   assign ge       = ~diff[REM_W+1];
   assign step_rem = ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
   assign step_quo = {quo_ff[EXT_W-2:0], ge};

   assign out_free = ~valid_ff | pop;
   assign q_pop    = (state_ff == ST_IDLE) & ~q_empty;

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      ext_in   = ext_ff;
      mhz_in   = mhz_ff;
      sec_in   = sec_ff;
      ms_in    = ms_ff;
      us_in    = us_ff;
      valid_in = valid_ff & ~pop;
      o_ext_in = o_ext_ff;
      o_sec_in = o_sec_ff;
      o_ms_in  = o_ms_ff;
      o_us_in  = o_us_ff;
      o_tot_in = o_tot_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               ext_in   = q_item.ext;
               mhz_in   = q_item.mhz;
               rem_in   = '0;
               quo_in   = q_item.ext;
               iter_in  = ITER_W'(EXT_W - 1);
               state_in = ST_SEC;
            end
         end
         ST_SEC, ST_MS, ST_US: begin
            rem_in  = step_rem;
            quo_in  = step_quo;
            iter_in = iter_ff - ITER_W'(1);
            if (iter_ff == '0) begin
               // next split has a quotient below 1000: start with the low bits only
               rem_in  = REM_W'(step_rem >> SUB_W);
               quo_in  = {step_rem[SUB_W-1:0], {(EXT_W - SUB_W){1'b0}}};
               iter_in = ITER_W'(SUB_W - 1);
               if (state_ff == ST_SEC) begin
                  sec_in   = step_quo[ccext_pkg::SEC_W-1:0];
                  state_in = ST_MS;
               end else if (state_ff == ST_MS) begin
                  ms_in    = step_quo[SUB_W-1:0];
                  state_in = ST_US;
               end else begin
                  us_in    = step_quo[SUB_W-1:0];
                  state_in = ST_TOTAL;
               end
            end
         end
         ST_TOTAL: begin
            if (out_free) begin
               valid_in = 1'b1;
               o_ext_in = ext_ff;
               o_sec_in = sec_ff;
               o_ms_in  = ms_ff;
               o_us_in  = us_ff;
               o_tot_in = ccext_pkg::TOTAL_W'(sec_ff)
                             * ccext_pkg::TOTAL_W'(ccext_pkg::US_PER_S)
                          + ccext_pkg::TOTAL_W'(ms_ff)
                             * ccext_pkg::TOTAL_W'(ccext_pkg::US_PER_MS)
                          + ccext_pkg::TOTAL_W'(us_ff);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      iter_ff  <= iter_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      ext_ff   <= ext_in;
      mhz_ff   <= mhz_in;
      sec_ff   <= sec_in;
      ms_ff    <= ms_in;
      us_ff    <= us_in;
      o_ext_ff <= o_ext_in;
      o_sec_ff <= o_sec_in;
      o_ms_ff  <= o_ms_in;
      o_us_ff  <= o_us_in;
      o_tot_ff <= o_tot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign empty                  = ~valid_ff;
   assign rsp_extended_count     = o_ext_ff;
   assign rsp_seconds            = o_sec_ff;
   assign rsp_milliseconds       = o_ms_ff;
   assign rsp_microseconds       = o_us_ff;
   assign rsp_total_microseconds = o_tot_ff;

`ifndef NO_ASSERTIONS
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEC || state_ff == ST_MS || state_ff == ST_US) |-> rem_ff < divisor)
      else $error("partial remainder not below divisor");

   a_sub_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TOTAL |-> (ms_ff < ccext_pkg::SUB_LIMIT && us_ff < ccext_pkg::SUB_LIMIT))
      else $error("sub-second split out of range");

   a_short_split: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MS || state_ff == ST_US) |-> iter_ff < ITER_W'(SUB_W))
      else $error("short split runs too long");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff == ST_SEC)
      else $error("queue word taken without starting the split");
`endif

endmodule

/* src/cycle_count_extend_and_split_unit.sv */
// top level of the cycle count extend and split unit
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------------
//  request  | in        | push / full        | req_counter_sample
//  response | out       | empty / pop        | extended count, seconds, ms, us, total us
//  csr      | in        | csr_wr_en          | csr_wr_data (clock in MHz, reset 1)
//
//  in the back end a word is loaded, then divided over all 64 dividend bits for
//  the seconds and over 10 bits each for milliseconds and microseconds, and the
//  total is formed once the result register is free; the divider is single-step restoring
//  the front end takes a word in the cycle it arrives while the queue has room,
//  and the result register lets the next word proceed while a result waits
//  synchronous active-high reset clears wrap count, previous sample, clock
//  (to 1 MHz), queue and result valid
module cycle_count_extend_and_split_unit #(
   parameter int COUNTER_WIDTH = ccext_pkg::COUNTER_WIDTH_DEF,
   parameter int FIFO_DEPTH    = ccext_pkg::FIFO_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   // request side
   input  logic                            push,
   output logic                            full,
   input  logic [ccext_pkg::SAMPLE_W-1:0]  req_counter_sample,
   // response side
   output logic                            empty,
   input  logic                            pop,
   output logic [ccext_pkg::EXT_W-1:0]     rsp_extended_count,
   output logic [ccext_pkg::SEC_W-1:0]     rsp_seconds,
   output logic [ccext_pkg::SUB_W-1:0]     rsp_milliseconds,
   output logic [ccext_pkg::SUB_W-1:0]     rsp_microseconds,
   output logic [ccext_pkg::TOTAL_W-1:0]   rsp_total_microseconds,
   // clock rate register
   input  logic                            csr_wr_en,
   input  logic [ccext_pkg::MHZ_W-1:0]     csr_wr_data
);

   // queue handshake between front and back
   logic                 q_push;
   logic                 q_full;
   logic                 q_empty;
   logic                 q_pop;
   ccext_pkg::item_type  q_wr_item;
   ccext_pkg::item_type  q_rd_item;

   assign full = q_full;

   // front: wrap detection and word build, one word per cycle while the queue has room
   ccext_front #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .req_counter_sample (req_counter_sample),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_item             (q_wr_item)
   );

   // decouples the front from the long divide
   ccext_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr      (q_push),
      .wr_item (q_wr_item),
      .rd      (q_pop),
      .rd_item (q_rd_item),
      .full    (q_full),
      .empty   (q_empty)
   );

   // back: time split and result register
   ccext_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .q_empty                (q_empty),
      .q_item                 (q_rd_item),
      .q_pop                  (q_pop),
      .pop                    (pop),
      .empty                  (empty),
      .rsp_extended_count     (rsp_extended_count),
      .rsp_seconds            (rsp_seconds),
      .rsp_milliseconds       (rsp_milliseconds),
      .rsp_microseconds       (rsp_microseconds),
      .rsp_total_microseconds (rsp_total_microseconds)
   );

endmodule
